// ===== rtl/text_console_cursor_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Text console cursor engine - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TCCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define TCCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, types and helpers of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_TAB    = 16;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 6;
    localparam int NC_W       = 8;
    localparam int NR_W       = 7;
    localparam int TW_W       = 5;
    localparam int POS_W      = 13;
    localparam int CNT_W      = 8;
    localparam int CH_W       = 8;
    localparam int PROD_W     = ROW_W + NC_W;
    localparam int SUM_W      = PROD_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USED_W = 2 * POS_W + CNT_W + CH_W + 1;

    localparam int DIV_CNT_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS   = 2'd0,
        CFG_ROWS      = 2'd1,
        CFG_TAB_STOP  = 2'd2
    } t_cfg_idx;

    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_BS    = 8'h08;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_NONE  = 8'h00;

    localparam logic [NC_W-1:0] COLS_RST = 8'd80;
    localparam logic [NR_W-1:0] ROWS_RST = 7'd25;
    localparam logic [TW_W-1:0] TAB_RST  = 5'd8;

    typedef enum logic [2:0] {
        K_SET   = 3'd0,
        K_BS    = 3'd1,
        K_NL    = 3'd2,
        K_TAB   = 3'd3,
        K_PRINT = 3'd4
    } t_kind;

    // Sequencer commands to the datapath.
    typedef struct packed {
        logic capture;
        logic div_step;
        logic calc;
        logic mul_start;
        logic mul_cursor;
        logic load_out;
    } t_dp_cmd;

    // Datapath status back to the sequencer.
    typedef struct packed {
        logic in_is_tab;
        logic div_done;
    } t_dp_sts;

    function automatic logic [NC_W-1:0] clamp_cols(input logic [CFG_DATA_W-1:0] v);
        logic [NC_W-1:0] res;
        if (v == '0)
            res = NC_W'(1);
        else if (v > CFG_DATA_W'(MAX_COLS))
            res = NC_W'(MAX_COLS);
        else
            res = NC_W'(v);
        return res;
    endfunction

    function automatic logic [NR_W-1:0] clamp_rows(input logic [CFG_DATA_W-1:0] v);
        logic [NR_W-1:0] res;
        if (v[NR_W-1:0] == '0)
            res = NR_W'(1);
        else if (v[NR_W-1:0] > NR_W'(MAX_ROWS))
            res = NR_W'(MAX_ROWS);
        else
            res = v[NR_W-1:0];
        return res;
    endfunction

    function automatic logic [TW_W-1:0] clamp_tab(input logic [CFG_DATA_W-1:0] v);
        logic [TW_W-1:0] res;
        if (v[TW_W-1:0] == '0)
            res = TW_W'(1);
        else if (v[TW_W-1:0] > TW_W'(MAX_TAB))
            res = TW_W'(MAX_TAB);
        else
            res = v[TW_W-1:0];
        return res;
    endfunction

endpackage

// ===== rtl/tcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer: accepts an item, steps the tab divider, the update and the
// two position multiplies, and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_defines.svh"

module tcce_ctrl
    import tcce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_CALC = 6'b000100,
        S_MULS = 6'b001000,
        S_MULC = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_sts.in_is_tab ? S_DIV : S_CALC;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_MULS;
            end
            S_MULS: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MULC;
            end
            S_MULC: begin
                o_cmd.mul_cursor = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out)
            n_out_valid = 1'b1;
        else if (i_out_ready)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `TCCE_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != S_IDLE, "accepted item did not start work")
    `TCCE_ASSERT_IMP(a_load_slot_free, i_clk, i_rst_n, o_cmd.load_out, w_slot_free, "result overwrote an untaken result")
    `TCCE_ASSERT_NXT(a_div_exit, i_clk, i_rst_n, (r_state == S_DIV) && i_sts.div_done, r_state == S_CALC, "divider exit missed")
    `TCCE_ASSERT_IMP(a_valid_from_load, i_clk, i_rst_n, $rose(r_out_valid), $past(o_cmd.load_out), "result valid without a load")

endmodule

// ===== rtl/tcce_dp.sv =====
// ----------------------------------------------------------------------------
// tcce_dp
// Datapath: configuration, cursor state, tab-stop divider, cursor update,
// row*columns+col multiplier and the output register.
// ----------------------------------------------------------------------------
module tcce_dp
    import tcce_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_action,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // configuration, held as effective (clamped) values
    logic [NC_W-1:0]       r_nc;
    logic [NR_W-1:0]       r_nr;
    logic [TW_W-1:0]       r_tw;

    // cursor state
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;

    // per-item working registers
    t_kind                 r_kind;
    logic [CH_W-1:0]       r_ch;
    logic [ROW_W-1:0]      r_wr;
    logic [COL_W-1:0]      r_wc;
    logic [ROW_W-1:0]      r_sr;
    logic [COL_W-1:0]      r_sc;
    logic [TW_W-1:0]       r_rem;
    logic [DIV_CNT_W-1:0]  r_qcnt;
    logic [CNT_W-1:0]      r_cnt;
    logic [CH_W-1:0]       r_fch;
    logic                  r_scr;
    logic [POS_W-1:0]      r_start;
    logic [POS_W-1:0]      r_pos;
    logic [OUT_DATA_W-1:0] r_out;

    logic [CH_W-1:0]       w_in_ch;
    logic [ROW_W-1:0]      w_in_srow;
    logic [COL_W-1:0]      w_in_scol;
    logic [NC_W-1:0]       w_nc_m1;
    logic [NR_W-1:0]       w_nr_m1;
    logic [ROW_W-1:0]      w_cur_r;
    logic [COL_W-1:0]      w_cur_c;
    logic [ROW_W-1:0]      w_set_r;
    logic [COL_W-1:0]      w_set_c;
    t_kind                 w_kind;

    logic [TW_W:0]         w_rem_sh;
    logic                  w_rem_ge;
    logic [DIV_CNT_W-1:0]  w_bit_idx;

    logic [NC_W-1:0]       w_c8;
    logic [NC_W-1:0]       w_tab_c;
    logic [NC_W-1:0]       w_newc;
    logic                  w_wrap;
    logic [NR_W-1:0]       w_r_nxt;
    logic                  w_ovf;
    logic [ROW_W-1:0]      w_adv_r;
    logic [COL_W-1:0]      w_adv_c;
    logic                  w_home;
    logic [ROW_W-1:0]      w_bs_r;
    logic [COL_W-1:0]      w_bs_c;

    logic [ROW_W-1:0]      n_sr, n_wr;
    logic [COL_W-1:0]      n_sc, n_wc;
    logic [CNT_W-1:0]      n_cnt;
    logic [CH_W-1:0]       n_fch;
    logic                  n_scr;

    logic [ROW_W-1:0]      w_mul_r;
    logic [COL_W-1:0]      w_mul_c;
    logic [PROD_W-1:0]     w_prod;
    logic [SUM_W-1:0]      w_sum;

    // input fields, lowest first: ch, set_row, set_col
    assign w_in_ch   = i_in_data[CH_W-1:0];
    assign w_in_srow = i_in_data[CH_W +: ROW_W];
    assign w_in_scol = i_in_data[CH_W+ROW_W +: COL_W];

    assign w_nc_m1 = r_nc - NC_W'(1);
    assign w_nr_m1 = r_nr - NR_W'(1);

    // clamp the cursor into the current screen, and the set request too
    assign w_cur_r = ({1'b0, r_row} < r_nr) ? r_row : w_nr_m1[ROW_W-1:0];
    assign w_cur_c = ({1'b0, r_col} < r_nc) ? r_col : w_nc_m1[COL_W-1:0];
    assign w_set_r = ({1'b0, w_in_srow} < r_nr) ? w_in_srow : w_nr_m1[ROW_W-1:0];
    assign w_set_c = ({1'b0, w_in_scol} < r_nc) ? w_in_scol : w_nc_m1[COL_W-1:0];

    always_comb begin
        if (i_in_action)
            w_kind = K_SET;
        else if (w_in_ch == CH_BS)
            w_kind = K_BS;
        else if ((w_in_ch == CH_CR) || (w_in_ch == CH_LF))
            w_kind = K_NL;
        else if (w_in_ch == CH_TAB)
            w_kind = K_TAB;
        else
            w_kind = K_PRINT;
    end

    assign o_sts.in_is_tab = (w_kind == K_TAB);
    assign o_sts.div_done  = (r_qcnt == DIV_CNT_W'(COL_W - 1));

    // restoring remainder, one column bit per step, MSB first
    assign w_bit_idx = DIV_CNT_W'(COL_W - 1) - r_qcnt;
    assign w_rem_sh  = {r_rem, r_wc[w_bit_idx]};
    assign w_rem_ge  = (w_rem_sh >= {1'b0, r_tw});

    // advance for newline, tab and printable
    assign w_c8    = {1'b0, r_wc};
    assign w_tab_c = w_c8 - NC_W'(r_rem) + NC_W'(r_tw);

    always_comb begin
        unique case (r_kind)
            K_NL:    w_newc = r_nc;
            K_TAB:   w_newc = (w_tab_c > r_nc) ? r_nc : w_tab_c;
            default: w_newc = w_c8 + NC_W'(1);
        endcase
    end

    assign w_wrap  = (w_newc >= r_nc);
    assign w_r_nxt = w_wrap ? ({1'b0, r_wr} + NR_W'(1)) : {1'b0, r_wr};
    assign w_ovf   = (w_r_nxt >= r_nr);
    assign w_adv_r = w_ovf ? w_nr_m1[ROW_W-1:0] : w_r_nxt[ROW_W-1:0];
    assign w_adv_c = w_wrap ? '0 : w_newc[COL_W-1:0];

    // backspace: step back one cell; from column 0 onto the last column of the line above
    assign w_home = (r_wr == '0) && (r_wc == '0);
    always_comb begin
        if (r_wc != '0) begin
            w_bs_r = r_wr;
            w_bs_c = r_wc - COL_W'(1);
        end else if (w_home) begin
            w_bs_r = r_wr;
            w_bs_c = r_wc;
        end else begin
            w_bs_r = r_wr - ROW_W'(1);
            w_bs_c = w_nc_m1[COL_W-1:0];
        end
    end

    always_comb begin
        n_sr  = r_wr;
        n_sc  = r_wc;
        n_wr  = r_wr;
        n_wc  = r_wc;
        n_cnt = '0;
        n_fch = CH_NONE;
        n_scr = 1'b0;
        unique case (r_kind)
            K_SET: begin
                n_sr = r_wr;
            end
            K_BS: begin
                n_sr = w_bs_r;
                n_sc = w_bs_c;
                n_wr = w_bs_r;
                n_wc = w_bs_c;
                if (!w_home) begin
                    n_cnt = CNT_W'(1);
                    n_fch = CH_SPACE;
                end
            end
            K_NL, K_TAB, K_PRINT: begin
                n_wr  = w_adv_r;
                n_wc  = w_adv_c;
                n_cnt = w_newc - w_c8;
                n_fch = (r_kind == K_PRINT) ? r_ch : CH_SPACE;
                n_scr = w_ovf;
            end
            default: begin
                n_sr = r_wr;
            end
        endcase
    end

    // one multiplier, shared by fill start and cursor position
    assign w_mul_r = i_cmd.mul_start ? r_sr : r_wr;
    assign w_mul_c = i_cmd.mul_start ? r_sc : r_wc;
    assign w_prod  = PROD_W'(w_mul_r) * PROD_W'(r_nc);
    assign w_sum   = SUM_W'(w_prod) + SUM_W'(w_mul_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc  <= COLS_RST;
            r_nr  <= ROWS_RST;
            r_tw  <= TAB_RST;
            r_row <= '0;
            r_col <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COLUMNS:   r_nc <= clamp_cols(i_cfg_data);
                    CFG_ROWS:      r_nr <= clamp_rows(i_cfg_data);
                    CFG_TAB_STOP:  r_tw <= clamp_tab(i_cfg_data);
                    default: begin
                        r_nc <= r_nc;
                    end
                endcase
            end
            if (i_cmd.calc) begin
                r_row <= n_wr;
                r_col <= n_wc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= w_kind;
            r_ch   <= w_in_ch;
            r_wr   <= i_in_action ? w_set_r : w_cur_r;
            r_wc   <= i_in_action ? w_set_c : w_cur_c;
            r_rem  <= '0;
            r_qcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_rem_ge ? TW_W'(w_rem_sh - {1'b0, r_tw}) : w_rem_sh[TW_W-1:0];
            r_qcnt <= r_qcnt + DIV_CNT_W'(1);
        end
        if (i_cmd.calc) begin
            r_sr  <= n_sr;
            r_sc  <= n_sc;
            r_wr  <= n_wr;
            r_wc  <= n_wc;
            r_cnt <= n_cnt;
            r_fch <= n_fch;
            r_scr <= n_scr;
        end
        if (i_cmd.mul_start) begin
            r_start <= w_sum[POS_W-1:0];
        end
        if (i_cmd.mul_cursor) begin
            r_pos <= w_sum[POS_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out <= {(OUT_DATA_W - OUT_USED_W)'(0), r_pos, r_scr, r_fch, r_cnt, r_start};
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text-mode console cursor engine: one screen-update command per character or set-cursor item.
// ----------------------------------------------------------------------------
// Each accepted item (a character to draw or a cursor move) yields exactly one
// command: fill fill_count cells from linear cell fill_start with fill_char,
// scroll up one line if scrolled is set (whole new last line cleared), and
// load cursor_addr into the CRT cursor registers. Printable bytes write one
// cell, CR/LF pad with spaces to the line end, tab pads to the next tab stop
// (clamped at the line end), backspace blanks the previous cell and does
// nothing at home. Set-cursor requests are clamped to the screen.
// Sequence: a tab item first finds its tab-stop remainder with a 7-step
// restoring divider, one column bit per cycle. Every item then goes through
// the cursor update and two passes through the one row*columns+col multiplier.
// The result waits to enter the output register until the previous result
// has been taken. A new item is taken as soon as the engine is idle, even
// while the last result still waits in the output register. Configuration
// (columns, rows, tab stop spacing) is to be written by the user through
// i_cfg_* only while the engine is idle; the block does not enforce this.
// Values of zero or over the maximum are clamped on write; rows and tab stop
// spacing are judged from their low 7 and 5 bits only.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
    import tcce_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write port: 0 columns, 1 rows, 2 tab stop spacing
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // character / set-cursor items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // ch[7:0], set_row[13:8], set_col[20:14]
    input  logic                  s_axis_tuser,  // action: 0 draw, 1 set cursor

    // screen-update commands
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // fill_start[12:0], fill_count[20:13],
                                                 // fill_char[28:21], scrolled[29],
                                                 // cursor_addr[42:30]
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: one item at a time, output register decoupled
    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: config, cursor, divider, multiplier, output register
    tcce_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_action (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (m_axis_tdata)
    );

endmodule
